[rtl/core/ctcgd_pkg.sv]
// shared constants, types and controller/datapath interface structs for the
// greedy ctc decoder; no dependencies
package ctcgd_pkg;

  localparam int unsigned MAX_CLASSES = 8192;
  localparam int unsigned MAX_STEPS   = 1024;

  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned DICT_W    = 16;
  localparam int unsigned SYM_W     = 11;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned CLS_W     = $clog2(MAX_CLASSES);
  localparam int unsigned CLS_CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_SUMM = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_sum;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_busy;
  } sts_t;

endpackage

[rtl/core/ctcgd_div.sv]
// iterative signed-by-unsigned divider, one quotient bit per cycle
// depends on ctcgd_pkg
module ctcgd_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [ctcgd_pkg::SUM_W-1:0]    dividend,
  input  logic        [ctcgd_pkg::SYM_W-1:0]    divisor,
  output logic                                  busy,
  output logic        [ctcgd_pkg::SCORE_W-1:0]  quotient
);

  logic                              busy_r, busy_nxt;
  logic [ctcgd_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ctcgd_pkg::SYM_W-1:0]       rem_r, rem_nxt;
  logic [ctcgd_pkg::SUM_W-1:0]       quot_r, quot_nxt;
  logic                              neg_r, neg_nxt;
  logic [ctcgd_pkg::SYM_W:0]         rem_sh;
  logic [ctcgd_pkg::SYM_W:0]         rem_diff;
  logic                              ge;
  logic [ctcgd_pkg::SUM_W-1:0]       mag;
  logic [ctcgd_pkg::SUM_W-1:0]       quot_signed;

  assign mag      = dividend[ctcgd_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign rem_sh   = {rem_r, quot_r[ctcgd_pkg::SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign ge       = (rem_sh >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctcgd_pkg::DIV_CNT_W'(ctcgd_pkg::SUM_W);
      rem_nxt  = '0;
      quot_nxt = mag;
      neg_nxt  = dividend[ctcgd_pkg::SUM_W-1];
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_diff[ctcgd_pkg::SYM_W-1:0] : rem_sh[ctcgd_pkg::SYM_W-1:0];
      quot_nxt = {quot_r[ctcgd_pkg::SUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == ctcgd_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    neg_r  <= neg_nxt;
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign quot_signed = neg_r ? (~quot_r + 1'b1) : quot_r;
  assign quotient    = quot_signed[ctcgd_pkg::SCORE_W-1:0];
  assign busy        = busy_r;

endmodule

[rtl/core/ctcgd_datapath.sv]
// argmax, collapse and dictionary filter, score accumulation, output register
// depends on ctcgd_pkg and ctcgd_div
module ctcgd_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ctcgd_pkg::cmd_t                      cmd,
  output ctcgd_pkg::sts_t                      sts,
  input  logic                                 cfg_valid,
  input  logic        [ctcgd_pkg::DICT_W-1:0]  cfg_dict_size,
  input  logic signed [ctcgd_pkg::SCORE_W-1:0] in_class_score,
  input  logic                                 in_step_end,
  input  logic                                 in_seq_end,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_kind,
  output logic        [ctcgd_pkg::IDX_W-1:0]   out_char_index,
  output logic signed [ctcgd_pkg::SCORE_W-1:0] out_mean_score,
  output logic        [ctcgd_pkg::SYM_W-1:0]   out_symbol_count,
  output logic                                 out_last
);

  logic [ctcgd_pkg::DICT_W-1:0]         dict_size_r;
  logic [ctcgd_pkg::CLS_CNT_W-1:0]      class_cnt_r, class_cnt_nxt;
  logic signed [ctcgd_pkg::SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [ctcgd_pkg::CLS_W-1:0]          best_class_r, best_class_nxt;
  logic [ctcgd_pkg::CLS_W-1:0]          prev_class_r, prev_class_nxt;
  logic                                 prev_valid_r, prev_valid_nxt;
  logic signed [ctcgd_pkg::SUM_W-1:0]   acc_sum_r, acc_sum_nxt;
  logic [ctcgd_pkg::SYM_W-1:0]          emit_cnt_r, emit_cnt_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_kind_r, out_kind_nxt;
  logic [ctcgd_pkg::IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic signed [ctcgd_pkg::SCORE_W-1:0] out_mean_r, out_mean_nxt;
  logic [ctcgd_pkg::SYM_W-1:0]          out_sym_r, out_sym_nxt;

  logic                                 in_range;
  logic                                 take;
  logic signed [ctcgd_pkg::SCORE_W-1:0] cur_score;
  logic [ctcgd_pkg::CLS_W-1:0]          cur_class;
  logic                                 step_done;
  logic                                 winner;
  logic                                 counted;
  logic [ctcgd_pkg::IDX_W-1:0]          char_idx;
  logic                                 in_dict;
  logic                                 div_busy;
  logic [ctcgd_pkg::SCORE_W-1:0]        div_quot;

  ctcgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_sum_r),
    .divisor  (emit_cnt_r),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign in_range  = (class_cnt_r < ctcgd_pkg::CLS_CNT_W'(ctcgd_pkg::MAX_CLASSES));
  assign take      = in_range && ((class_cnt_r == '0) || (in_class_score > best_score_r));
  assign cur_score = take ? in_class_score : best_score_r;
  assign cur_class = take ? class_cnt_r[ctcgd_pkg::CLS_W-1:0] : best_class_r;
  assign step_done = in_step_end || in_seq_end;
  // blank and repeats of the previous step's winner collapse away
  assign winner    = (cur_class != '0) && (!prev_valid_r || (cur_class != prev_class_r));
  assign counted   = winner && (emit_cnt_r < ctcgd_pkg::SYM_W'(ctcgd_pkg::MAX_STEPS));
  assign char_idx  = ctcgd_pkg::IDX_W'(cur_class) - 1'b1;
  assign in_dict   = (char_idx < dict_size_r);

  always_comb begin
    class_cnt_nxt  = class_cnt_r;
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    prev_class_nxt = prev_class_r;
    prev_valid_nxt = prev_valid_r;
    acc_sum_nxt    = acc_sum_r;
    emit_cnt_nxt   = emit_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_idx_nxt    = out_idx_r;
    out_mean_nxt   = out_mean_r;
    out_sym_nxt    = out_sym_r;
    if (cmd.accept) begin
      if (step_done) begin
        if (counted) begin
          acc_sum_nxt  = acc_sum_r + ctcgd_pkg::SUM_W'(cur_score);
          emit_cnt_nxt = emit_cnt_r + 1'b1;
        end
        if (winner && in_dict) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ctcgd_pkg::KIND_CHAR;
          out_idx_nxt   = char_idx;
          out_mean_nxt  = '0;
          out_sym_nxt   = '0;
        end
        prev_class_nxt = cur_class;
        prev_valid_nxt = 1'b1;
        class_cnt_nxt  = '0;
        best_score_nxt = '0;
        best_class_nxt = '0;
      end else begin
        best_score_nxt = cur_score;
        best_class_nxt = cur_class;
        if (in_range) begin
          class_cnt_nxt = class_cnt_r + 1'b1;
        end
      end
    end else if (cmd.load_sum) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = ctcgd_pkg::KIND_SUMMARY;
      out_idx_nxt    = '0;
      out_mean_nxt   = (emit_cnt_r == '0) ? '0 : div_quot;
      out_sym_nxt    = emit_cnt_r;
      class_cnt_nxt  = '0;
      best_score_nxt = '0;
      best_class_nxt = '0;
      prev_class_nxt = '0;
      prev_valid_nxt = 1'b0;
      acc_sum_nxt    = '0;
      emit_cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_size_r  <= '1;
      class_cnt_r  <= '0;
      best_score_r <= '0;
      best_class_r <= '0;
      prev_class_r <= '0;
      prev_valid_r <= 1'b0;
      acc_sum_r    <= '0;
      emit_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dict_size_r <= cfg_dict_size;
      end
      class_cnt_r  <= class_cnt_nxt;
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      prev_class_r <= prev_class_nxt;
      prev_valid_r <= prev_valid_nxt;
      acc_sum_r    <= acc_sum_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_mean_r <= out_mean_nxt;
    out_sym_r  <= out_sym_nxt;
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.div_busy = div_busy;

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_char_index   = out_idx_r;
  assign out_mean_score   = out_mean_r;
  assign out_symbol_count = out_sym_r;
  assign out_last         = (out_kind_r == ctcgd_pkg::KIND_SUMMARY);

`ifndef SYNTHESIS
  a_emit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    emit_cnt_r <= ctcgd_pkg::SYM_W'(ctcgd_pkg::MAX_STEPS))
    else $error("symbol count beyond limit");

  a_sum_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_sum |-> (!out_valid_r || out_ready))
    else $error("summary would overwrite a pending result");

  a_class_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    class_cnt_r <= ctcgd_pkg::CLS_CNT_W'(ctcgd_pkg::MAX_CLASSES))
    else $error("class counter past saturation");
`endif

endmodule

[rtl/core/ctcgd_ctrl.sv]
// sequence controller: streams scores, then runs the mean division and
// issues the summary; depends on ctcgd_pkg
module ctcgd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_seq_end,
  output logic            in_ready,
  input  ctcgd_pkg::sts_t sts,
  output ctcgd_pkg::cmd_t cmd
);

  ctcgd_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load_sum  = 1'b0;
    case (state_r)
      ctcgd_pkg::ST_RUN: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && in_seq_end) begin
          state_nxt = ctcgd_pkg::ST_LOAD;
        end
      end
      // sum and count of the last step are settled in the cycle after its transaction
      ctcgd_pkg::ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = ctcgd_pkg::ST_DIV;
      end
      ctcgd_pkg::ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ctcgd_pkg::ST_SUMM;
        end
      end
      ctcgd_pkg::ST_SUMM: begin
        if (sts.out_free) begin
          cmd.load_sum = 1'b1;
          state_nxt    = ctcgd_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = ctcgd_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctcgd_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ctcgd_pkg::ST_RUN))
    else $error("input ready outside streaming");

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

  a_seq_end_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_seq_end) |=> (state_r == ctcgd_pkg::ST_LOAD))
    else $error("sequence end not followed by division");
`endif

endmodule

[rtl/core/ctc_greedy_decoder_top.sv]
// Greedy CTC decoder. Class scores (signed Q4.12) stream in one per cycle
// while in_ready is high, class 0 first; a running argmax keeps the first
// maximum of each step. At a step end the winner is dropped if it is blank
// or repeats the previous step, otherwise it is counted and its score summed
// (up to 1024 symbols), and a character result is sent if winner-1 is below
// dict_size. While streaming and the output register is free or being
// drained, one score is taken every cycle. A transaction with seq_end causes
// a summary after bit-serial division of the score sum by the symbol count,
// via the LOAD, DIV and SUMM states; it is registered once the division is
// done and the output is free, and in_ready stays low until then. cfg writes
// are always taken and should only be issued while the block is idle.
// depends on ctcgd_pkg, ctcgd_ctrl, ctcgd_datapath
module ctc_greedy_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [ctcgd_pkg::DICT_W-1:0]  cfg_dict_size,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ctcgd_pkg::SCORE_W-1:0] in_class_score,
  input  logic                                 in_step_end,
  input  logic                                 in_seq_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic        [ctcgd_pkg::IDX_W-1:0]   out_char_index,
  output logic signed [ctcgd_pkg::SCORE_W-1:0] out_mean_score,
  output logic        [ctcgd_pkg::SYM_W-1:0]   out_symbol_count,
  output logic                                 out_last
);

  ctcgd_pkg::cmd_t cmd;
  ctcgd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ctcgd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_seq_end (in_seq_end),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ctcgd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_dict_size    (cfg_dict_size),
    .in_class_score   (in_class_score),
    .in_step_end      (in_step_end),
    .in_seq_end       (in_seq_end),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_char_index   (out_char_index),
    .out_mean_score   (out_mean_score),
    .out_symbol_count (out_symbol_count),
    .out_last         (out_last)
  );

endmodule
